[src/lavm_pkg.sv]
// Shared types, constants and helper functions for the look-at view matrix unit.
// Depends on nothing; used by look_at_view_matrix_unit.
`timescale 1ns / 1ps
`default_nettype none
package lavm_pkg;

   localparam int POS_W = 32;
   localparam int DIR_W = 16;
   localparam int VAL_W = 48;
   localparam int ROW_W = 2;
   localparam int REQ_W = 144;
   localparam int RSP_W = 152;
   localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;
   localparam logic signed [63:0] VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] VAL_MIN = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
      logic                    dgn;
   } carry_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_state_type;

   function automatic logic [15:0] abs16(logic signed [15:0] x);
      abs16 = x[15] ? 16'(-x) : 16'(x);
   endfunction

   function automatic logic [31:0] abs32(logic signed [31:0] x);
      abs32 = x[31] ? 32'(-x) : 32'(x);
   endfunction

   // One step of the digit-by-digit square root; bit_val is a power of four.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s, logic [63:0] bit_val);
      logic [64:0] trial;
      sqrt_state_type o;
      trial = {1'b0, s.root} + {1'b0, bit_val};
      if ({1'b0, s.rem} >= trial) begin
         o.rem  = s.rem - trial[63:0];
         o.root = (s.root >> 1) + bit_val;
      end else begin
         o.rem  = s.rem;
         o.root = s.root >> 1;
      end
      sqrt_step = o;
   endfunction

   // Returns the negated quotient n / 2^s, rounded half away from zero.
   function automatic logic signed [63:0] neg_round(logic signed [63:0] n, int s);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] q;
      mag  = n[63] ? 64'(-n) : 64'(n);
      half = 64'd1 << (s - 1);
      q    = (mag + half) >> s;
      neg_round = n[63] ? $signed(q) : -$signed(q);
   endfunction

   function automatic logic signed [VAL_W-1:0] sat48(logic signed [63:0] v);
      if (v > VAL_MAX) begin
         sat48 = VAL_W'(VAL_MAX);
      end else if (v < VAL_MIN) begin
         sat48 = VAL_W'(VAL_MIN);
      end else begin
         sat48 = VAL_W'(v);
      end
   endfunction

endpackage
`default_nettype wire

[src/look_at_view_matrix_unit.sv]
// Look-at view matrix unit: builds a left-handed view matrix from position and direction.
// Depends on lavm_pkg for shared types and arithmetic helpers.
//
// Usage: one beat on the req_ channel carries a camera position (three signed Q16.16
// values) and a look direction (three signed Q1.14 values). For each accepted beat the
// unit sends four beats on the rsp_ channel, rows 0 to 3 of the matrix; tlast marks row 3
// and tuser flags a look direction parallel to the Y axis, in which case all values are
// zero. The work runs through a pipeline of FRAC_BITS + 42 register stages: input
// register, squares, radicands, 32 square root steps, dividend setup, FRAC_BITS + 2
// restoring divide steps for five quotients, sign, products, sums, and rounding. The
// rounding stage loads a four-row output buffer that presents row 0 first on the rsp_
// channel; the sustained rate is set by the four result beats per item on the single
// result channel. Several items are in flight at once. When the receiver stalls, the
// whole pipeline holds and req_tready falls once the last stage is full; nothing is
// lost or repeated. Synchronous reset empties the pipeline and the output buffer.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
   input  logic [lavm_pkg::REQ_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row_index, col_a, col_b, col_c, zero fill
   output logic [lavm_pkg::RSP_W-1:0] rsp_tdata,
   output logic        rsp_tlast,
   // degenerate
   output logic [0:0]  rsp_tuser
);

   localparam int QB  = FRAC_BITS + 2;
   localparam int QW  = QB + 1;
   localparam int NW  = FRAC_BITS + 32;
   localparam int DW  = FRAC_BITS + 34;
   localparam int PW  = QW + 32;
   localparam int LS  = 30 - FRAC_BITS;
   localparam int LUP = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
   localparam int LDN = (FRAC_BITS >= 14) ? 1 : 14 - FRAC_BITS;
   localparam int SQ  = 32;
   localparam int NL  = 5;

   typedef struct packed {
      logic signed [QW-1:0] rx;
      logic signed [QW-1:0] rz;
      logic signed [QW-1:0] ux;
      logic signed [QW-1:0] uy;
      logic signed [QW-1:0] uz;
      logic signed [47:0]   lfx;
      logic signed [47:0]   lfy;
      logic signed [47:0]   lfz;
      logic                 dgn;
   } axes_type;

   logic adv;
   logic ser_take;
   logic ser_done;
   logic ser_load;

   // Input register.
   logic                 a_vld_ff;
   lavm_pkg::carry_type  a_car_ff;
   lavm_pkg::carry_type  a_car_in;

   always_comb begin
      a_car_in.pos_x = req_tdata[31:0];
      a_car_in.pos_y = req_tdata[63:32];
      a_car_in.pos_z = req_tdata[95:64];
      a_car_in.dir_x = req_tdata[111:96];
      a_car_in.dir_y = req_tdata[127:112];
      a_car_in.dir_z = req_tdata[143:128];
      a_car_in.dgn   = (req_tdata[111:96] == '0) && (req_tdata[143:128] == '0);
   end

   // Squares and cross products of the direction.
   logic                 b_vld_ff;
   lavm_pkg::carry_type  b_car_ff;
   logic [31:0]          b_h2_ff;
   logic [31:0]          b_ly2_ff;
   logic signed [31:0]   b_lylx_ff;
   logic signed [31:0]   b_lylz_ff;
   logic signed [31:0]   b_sqx_in;
   logic signed [31:0]   b_sqy_in;
   logic signed [31:0]   b_sqz_in;

   always_comb begin
      b_sqx_in = a_car_ff.dir_x * a_car_ff.dir_x;
      b_sqy_in = a_car_ff.dir_y * a_car_ff.dir_y;
      b_sqz_in = a_car_ff.dir_z * a_car_ff.dir_z;
   end

   // Radicands.
   logic                 c_vld_ff;
   lavm_pkg::carry_type  c_car_ff;
   logic [31:0]          c_h2_ff;
   logic signed [31:0]   c_lylx_ff;
   logic signed [31:0]   c_lylz_ff;
   logic [63:0]          c_radd_ff;
   logic [31:0]          c_n2_in;

   assign c_n2_in = b_h2_ff + b_ly2_ff;

   // Square root pipeline.
   logic                     sq_vld_ff  [0:SQ-1];
   lavm_pkg::carry_type      sq_car_ff  [0:SQ-1];
   logic [31:0]              sq_h2_ff   [0:SQ-1];
   logic signed [31:0]       sq_lylx_ff [0:SQ-1];
   logic signed [31:0]       sq_lylz_ff [0:SQ-1];
   lavm_pkg::sqrt_state_type sq_h_ff    [0:SQ-1];
   lavm_pkg::sqrt_state_type sq_d_ff    [0:SQ-1];

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
      logic                     vld_cur;
      lavm_pkg::carry_type      car_cur;
      logic [31:0]              h2_cur;
      logic signed [31:0]       lylx_cur;
      logic signed [31:0]       lylz_cur;
      lavm_pkg::sqrt_state_type h_cur;
      lavm_pkg::sqrt_state_type d_cur;
      if (j == 0) begin : g_head
         assign vld_cur  = c_vld_ff;
         assign car_cur  = c_car_ff;
         assign h2_cur   = c_h2_ff;
         assign lylx_cur = c_lylx_ff;
         assign lylz_cur = c_lylz_ff;
         assign h_cur    = '{rem: {c_h2_ff, 32'd0}, root: 64'd0};
         assign d_cur    = '{rem: c_radd_ff, root: 64'd0};
      end else begin : g_body
         assign vld_cur  = sq_vld_ff[j-1];
         assign car_cur  = sq_car_ff[j-1];
         assign h2_cur   = sq_h2_ff[j-1];
         assign lylx_cur = sq_lylx_ff[j-1];
         assign lylz_cur = sq_lylz_ff[j-1];
         assign h_cur    = sq_h_ff[j-1];
         assign d_cur    = sq_d_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[j] <= vld_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_car_ff[j]  <= car_cur;
            sq_h2_ff[j]   <= h2_cur;
            sq_lylx_ff[j] <= lylx_cur;
            sq_lylz_ff[j] <= lylz_cur;
            sq_h_ff[j]    <= lavm_pkg::sqrt_step(h_cur, SQ_BIT);
            sq_d_ff[j]    <= lavm_pkg::sqrt_step(d_cur, SQ_BIT);
         end
      end
   end

   // Dividend setup: magnitude plus half the divisor, sign kept aside.
   logic                 p_vld_ff;
   lavm_pkg::carry_type  p_car_ff;
   logic [31:0]          p_h_ff;
   logic [31:0]          p_d_ff;
   logic [NW-1:0]        p_mag_ff [0:NL-1];
   logic [NL-1:0]        p_sgn_ff;
   logic [NW-1:0]        p_mag_in [0:NL-1];
   logic [NL-1:0]        p_sgn_in;
   logic [31:0]          p_h_in;
   logic [31:0]          p_d_in;

   always_comb begin
      p_h_in = sq_h_ff[SQ-1].root[31:0];
      p_d_in = sq_d_ff[SQ-1].root[31:0];
      p_mag_in[0] = (NW'(lavm_pkg::abs16(sq_car_ff[SQ-1].dir_z)) << (FRAC_BITS + 16))
                    + NW'(p_h_in >> 1);
      p_mag_in[1] = (NW'(lavm_pkg::abs16(sq_car_ff[SQ-1].dir_x)) << (FRAC_BITS + 16))
                    + NW'(p_h_in >> 1);
      p_mag_in[2] = (NW'(lavm_pkg::abs32(sq_lylx_ff[SQ-1])) << FRAC_BITS) + NW'(p_d_in >> 1);
      p_mag_in[3] = (NW'(sq_h2_ff[SQ-1]) << FRAC_BITS) + NW'(p_d_in >> 1);
      p_mag_in[4] = (NW'(lavm_pkg::abs32(sq_lylz_ff[SQ-1])) << FRAC_BITS) + NW'(p_d_in >> 1);
      p_sgn_in[0] = sq_car_ff[SQ-1].dir_z[15];
      p_sgn_in[1] = sq_car_ff[SQ-1].dir_x > 0;
      p_sgn_in[2] = sq_lylx_ff[SQ-1] > 0;
      p_sgn_in[3] = 1'b0;
      p_sgn_in[4] = sq_lylz_ff[SQ-1] > 0;
   end

   // Restoring divide pipeline, one quotient bit per stage for five lanes.
   logic                 dv_vld_ff [0:QB-1];
   lavm_pkg::carry_type  dv_car_ff [0:QB-1];
   logic [31:0]          dv_h_ff   [0:QB-1];
   logic [31:0]          dv_d_ff   [0:QB-1];
   logic [NL-1:0]        dv_sgn_ff [0:QB-1];
   logic [NW-1:0]        dv_rem_ff [0:QB-1][0:NL-1];
   logic [QB-1:0]        dv_quo_ff [0:QB-1][0:NL-1];

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int SH = QB - 1 - j;
      logic                 vld_cur;
      lavm_pkg::carry_type  car_cur;
      logic [31:0]          h_cur;
      logic [31:0]          d_cur;
      logic [NL-1:0]        sgn_cur;
      logic [NW-1:0]        rem_cur [0:NL-1];
      logic [QB-1:0]        quo_cur [0:NL-1];
      logic [NW-1:0]        rem_in  [0:NL-1];
      logic [QB-1:0]        quo_in  [0:NL-1];
      if (j == 0) begin : g_head
         assign vld_cur = p_vld_ff;
         assign car_cur = p_car_ff;
         assign h_cur   = p_h_ff;
         assign d_cur   = p_d_ff;
         assign sgn_cur = p_sgn_ff;
         assign rem_cur = p_mag_ff;
         assign quo_cur = '{default: '0};
      end else begin : g_body
         assign vld_cur = dv_vld_ff[j-1];
         assign car_cur = dv_car_ff[j-1];
         assign h_cur   = dv_h_ff[j-1];
         assign d_cur   = dv_d_ff[j-1];
         assign sgn_cur = dv_sgn_ff[j-1];
         assign rem_cur = dv_rem_ff[j-1];
         assign quo_cur = dv_quo_ff[j-1];
      end
      always_comb begin
         logic [DW-1:0] dsh;
         for (int k = 0; k < NL; k++) begin
            dsh = (k < 2) ? (DW'(h_cur) << SH) : (DW'(d_cur) << SH);
            rem_in[k] = rem_cur[k];
            quo_in[k] = quo_cur[k];
            if (DW'(rem_cur[k]) >= dsh) begin
               rem_in[k]     = rem_cur[k] - NW'(dsh);
               quo_in[k][SH] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_car_ff[j] <= car_cur;
            dv_h_ff[j]   <= h_cur;
            dv_d_ff[j]   <= d_cur;
            dv_sgn_ff[j] <= sgn_cur;
            dv_rem_ff[j] <= rem_in;
            dv_quo_ff[j] <= quo_in;
         end
      end
   end

   // Signed axes and look column.
   logic                 g_vld_ff;
   axes_type             g_ax_ff;
   lavm_pkg::carry_type  g_car_ff;
   axes_type             g_ax_in;
   logic signed [QW-1:0] g_q_in [0:NL-1];

   function automatic logic signed [47:0] scale_dir(logic signed [15:0] v);
      logic signed [47:0] w;
      w = 48'(v);
      if (FRAC_BITS >= 14) begin
         scale_dir = w <<< LUP;
      end else begin
         scale_dir = 48'(-lavm_pkg::neg_round(64'(w), LDN));
      end
   endfunction

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         g_q_in[k] = dv_sgn_ff[QB-1][k] ? -$signed({1'b0, dv_quo_ff[QB-1][k]})
                                         :  $signed({1'b0, dv_quo_ff[QB-1][k]});
      end
      g_ax_in.rx  = g_q_in[0];
      g_ax_in.rz  = g_q_in[1];
      g_ax_in.ux  = g_q_in[2];
      g_ax_in.uy  = g_q_in[3];
      g_ax_in.uz  = g_q_in[4];
      g_ax_in.lfx = scale_dir(dv_car_ff[QB-1].dir_x);
      g_ax_in.lfy = scale_dir(dv_car_ff[QB-1].dir_y);
      g_ax_in.lfz = scale_dir(dv_car_ff[QB-1].dir_z);
      g_ax_in.dgn = dv_car_ff[QB-1].dgn;
   end

   // Products with the position.
   logic                 m_vld_ff;
   axes_type             m_ax_ff;
   logic signed [PW-1:0] m_prx_ff;
   logic signed [PW-1:0] m_prz_ff;
   logic signed [PW-1:0] m_pux_ff;
   logic signed [PW-1:0] m_puy_ff;
   logic signed [PW-1:0] m_puz_ff;
   logic signed [47:0]   m_plx_ff;
   logic signed [47:0]   m_ply_ff;
   logic signed [47:0]   m_plz_ff;

   // Dot product sums.
   logic                 s_vld_ff;
   axes_type             s_ax_ff;
   logic signed [63:0]   s_spr_ff;
   logic signed [63:0]   s_spu_ff;
   logic signed [63:0]   s_spl_ff;

   // Rounded translation; last pipeline stage.
   logic                 t_vld_ff;
   axes_type             t_ax_ff;
   logic signed [47:0]   t_ta_ff;
   logic signed [47:0]   t_tb_ff;
   logic signed [47:0]   t_tc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         t_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         p_vld_ff <= sq_vld_ff[SQ-1];
         g_vld_ff <= dv_vld_ff[QB-1];
         m_vld_ff <= g_vld_ff;
         s_vld_ff <= m_vld_ff;
         t_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_car_ff  <= a_car_in;
         b_car_ff  <= a_car_ff;
         b_h2_ff   <= unsigned'(b_sqx_in) + unsigned'(b_sqz_in);
         b_ly2_ff  <= unsigned'(b_sqy_in);
         b_lylx_ff <= a_car_ff.dir_y * a_car_ff.dir_x;
         b_lylz_ff <= a_car_ff.dir_y * a_car_ff.dir_z;
         c_car_ff  <= b_car_ff;
         c_h2_ff   <= b_h2_ff;
         c_lylx_ff <= b_lylx_ff;
         c_lylz_ff <= b_lylz_ff;
         c_radd_ff <= 64'(b_h2_ff) * 64'(c_n2_in);
         p_car_ff  <= sq_car_ff[SQ-1];
         p_h_ff    <= p_h_in;
         p_d_ff    <= p_d_in;
         p_mag_ff  <= p_mag_in;
         p_sgn_ff  <= p_sgn_in;
         g_ax_ff   <= g_ax_in;
         g_car_ff  <= dv_car_ff[QB-1];
         m_ax_ff   <= g_ax_ff;
         m_prx_ff  <= g_ax_ff.rx * g_car_ff.pos_x;
         m_prz_ff  <= g_ax_ff.rz * g_car_ff.pos_z;
         m_pux_ff  <= g_ax_ff.ux * g_car_ff.pos_x;
         m_puy_ff  <= g_ax_ff.uy * g_car_ff.pos_y;
         m_puz_ff  <= g_ax_ff.uz * g_car_ff.pos_z;
         m_plx_ff  <= g_car_ff.dir_x * g_car_ff.pos_x;
         m_ply_ff  <= g_car_ff.dir_y * g_car_ff.pos_y;
         m_plz_ff  <= g_car_ff.dir_z * g_car_ff.pos_z;
         s_ax_ff   <= m_ax_ff;
         s_spr_ff  <= 64'(m_prx_ff) + 64'(m_prz_ff);
         s_spu_ff  <= 64'(m_pux_ff) + 64'(m_puy_ff) + 64'(m_puz_ff);
         s_spl_ff  <= 64'(m_plx_ff) + 64'(m_ply_ff) + 64'(m_plz_ff);
         t_ax_ff   <= s_ax_ff;
         t_ta_ff   <= lavm_pkg::sat48(lavm_pkg::neg_round(s_spr_ff, 16));
         t_tb_ff   <= lavm_pkg::sat48(lavm_pkg::neg_round(s_spu_ff, 16));
         t_tc_ff   <= lavm_pkg::sat48(lavm_pkg::neg_round(s_spl_ff, LS));
      end
   end

   // Output buffer holding the four rows of one matrix.
   logic                          ser_vld_ff;
   logic [lavm_pkg::ROW_W-1:0]    ser_row_ff;
   logic                          ser_dgn_ff;
   logic signed [47:0]            ser_a_ff [0:3];
   logic signed [47:0]            ser_b_ff [0:3];
   logic signed [47:0]            ser_c_ff [0:3];
   logic signed [47:0]            ser_a_in [0:3];
   logic signed [47:0]            ser_b_in [0:3];
   logic signed [47:0]            ser_c_in [0:3];

   assign ser_take   = rsp_tvalid && rsp_tready;
   assign ser_done   = ser_take && (ser_row_ff == lavm_pkg::ROW_LAST);
   assign ser_load   = t_vld_ff && (!ser_vld_ff || ser_done);
   assign adv        = !t_vld_ff || ser_load;
   assign req_tready = adv;

   always_comb begin
      ser_a_in[0] = 48'(t_ax_ff.rx);
      ser_a_in[1] = '0;
      ser_a_in[2] = 48'(t_ax_ff.rz);
      ser_a_in[3] = t_ta_ff;
      ser_b_in[0] = 48'(t_ax_ff.ux);
      ser_b_in[1] = 48'(t_ax_ff.uy);
      ser_b_in[2] = 48'(t_ax_ff.uz);
      ser_b_in[3] = t_tb_ff;
      ser_c_in[0] = t_ax_ff.lfx;
      ser_c_in[1] = t_ax_ff.lfy;
      ser_c_in[2] = t_ax_ff.lfz;
      ser_c_in[3] = t_tc_ff;
      if (t_ax_ff.dgn) begin
         ser_a_in = '{default: '0};
         ser_b_in = '{default: '0};
         ser_c_in = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_row_ff <= '0;
      end else if (ser_load) begin
         ser_vld_ff <= 1'b1;
         ser_row_ff <= '0;
      end else if (ser_done) begin
         ser_vld_ff <= 1'b0;
      end else if (ser_take) begin
         ser_row_ff <= ser_row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_a_ff   <= ser_a_in;
         ser_b_ff   <= ser_b_in;
         ser_c_ff   <= ser_c_in;
         ser_dgn_ff <= t_ax_ff.dgn;
      end
   end

   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tlast  = (ser_row_ff == lavm_pkg::ROW_LAST);
   assign rsp_tuser  = ser_dgn_ff;
   assign rsp_tdata  = {6'd0, ser_c_ff[ser_row_ff], ser_b_ff[ser_row_ff],
                        ser_a_ff[ser_row_ff], ser_row_ff};

   a_load_starts_row0 : assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (rsp_tvalid && (ser_row_ff == '0)))
      else $error("Output buffer did not start at row 0 after a load.");

   a_tail_holds : assert property (@(posedge clock) disable iff (reset)
      (t_vld_ff && !adv) |=> (t_vld_ff && $stable(t_ax_ff) && $stable(t_ta_ff)))
      else $error("Last pipeline stage changed during a stall.");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[145:2] == '0))
      else $error("Degenerate row carries nonzero values.");

   a_rows_continue : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("Matrix ended before its last row.");

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for look_at_view_matrix_unit: drives position and direction beats
// and compares every matrix row against an internal fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int FRAC = 16;
   localparam int LIMIT = 400000;

   typedef struct {
      logic [1:0]        row;
      logic signed [47:0] a;
      logic signed [47:0] b;
      logic signed [47:0] c;
      logic              dgn;
      logic              last;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [151:0] rsp_tdata;
   logic rsp_tlast;
   logic [0:0] rsp_tuser;
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;
   bit stim_done = 0;

   look_at_view_matrix_unit #(.FRAC_BITS(FRAC)) uut (.*);

   task automatic report(string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   function automatic longint rnd_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, bv;
      r = 0;
      bv = 64'd1 << 62;
      while (bv > v) bv >>= 2;
      while (bv != 0) begin
         if (v >= r + bv) begin
            v -= r + bv;
            r = (r >> 1) + bv;
         end else begin
            r >>= 1;
         end
         bv >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic logic signed [47:0] clamp48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   class matrix_scoreboard;
      row_type rows_due[$];

      function void note_input(logic [143:0] d);
         longint p[3], l[3], r[3], u[3], lf[3], t[3];
         longint h2, n2, hh, dd, one, sr, su, sl;
         bit dgn;
         row_type e;
         for (int k = 0; k < 3; k++) begin
            p[k] = longint'($signed(d[32*k +: 32]));
            l[k] = longint'($signed(d[96 + 16*k +: 16]));
            r[k] = 0; u[k] = 0; lf[k] = 0; t[k] = 0;
         end
         h2 = l[0] * l[0] + l[2] * l[2];
         dgn = (h2 == 0);
         if (!dgn) begin
            n2 = h2 + l[1] * l[1];
            hh = int_sqrt(h2 << 32);
            dd = int_sqrt(h2 * n2);
            one = 64'sd1 << FRAC;
            r[0] = rnd_div(l[2] * (one << 16), hh);
            r[2] = rnd_div(-l[0] * (one << 16), hh);
            u[0] = rnd_div(-l[1] * l[0] * one, dd);
            u[1] = rnd_div(h2 * one, dd);
            u[2] = rnd_div(-l[1] * l[2] * one, dd);
            sr = 0; su = 0; sl = 0;
            for (int k = 0; k < 3; k++) begin
               lf[k] = l[k] * (64'sd1 << (FRAC - 14));
               sr += r[k] * p[k];
               su += u[k] * p[k];
               sl += l[k] * p[k];
            end
            t[0] = -rnd_div(sr, 64'sd1 << 16);
            t[1] = -rnd_div(su, 64'sd1 << 16);
            t[2] = -rnd_div(sl, 64'sd1 << (30 - FRAC));
         end
         for (int k = 0; k < 4; k++) begin
            e.row = k[1:0];
            e.a = clamp48(k < 3 ? r[k] : t[0]);
            e.b = clamp48(k < 3 ? u[k] : t[1]);
            e.c = clamp48(k < 3 ? lf[k] : t[2]);
            e.dgn = dgn;
            e.last = (k == 3);
            rows_due.push_back(e);
         end
      endfunction

      task check_row(row_type got);
         row_type e;
         if (rows_due.size() == 0) begin
            report("row arrived with nothing expected");
            return;
         end
         e = rows_due.pop_front();
         if (got.row !== e.row) report($sformatf("row_index %0d exp %0d", got.row, e.row));
         if (got.a !== e.a) report($sformatf("row %0d col_a %0d exp %0d", e.row, got.a, e.a));
         if (got.b !== e.b) report($sformatf("row %0d col_b %0d exp %0d", e.row, got.b, e.b));
         if (got.c !== e.c) report($sformatf("row %0d col_c %0d exp %0d", e.row, got.c, e.c));
         if (got.dgn !== e.dgn) report($sformatf("row %0d degenerate %0b", e.row, got.dgn));
         if (got.last !== e.last) report($sformatf("row %0d last %0b", e.row, got.last));
      endtask
   endclass

   matrix_scoreboard board = new();

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      row_type got;
      if (!reset && req_tvalid && req_tready) board.note_input(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[1:0];
         got.a = rsp_tdata[2 +: 48];
         got.b = rsp_tdata[50 +: 48];
         got.c = rsp_tdata[98 +: 48];
         got.dgn = rsp_tuser[0];
         got.last = rsp_tlast;
         board.check_row(got);
      end
   end

   // The receiver stalls on its own pattern, with one long hold-off early in the run.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else if (cycles == 600) begin
         hold_cycles <= 400;
         rsp_tready <= 0;
      end else if (cycles[10:9] == 2'b01) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   function automatic logic [143:0] make_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                              logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
      return {dz, dy, dx, pz, py, px};
   endfunction

   task automatic send(logic [143:0] d);
      req_tdata <= d;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [15:0] unit_dir_part(int idx, int ang, int elev);
      real th, ph, v;
      th = ang * 3.14159265 / 180.0;
      ph = elev * 3.14159265 / 180.0;
      case (idx)
         0: v = $cos(ph) * $sin(th);
         1: v = $sin(ph);
         default: v = $cos(ph) * $cos(th);
      endcase
      return 16'($rtoi(v * 16384.0));
   endfunction

   logic [143:0] directed[$];

   initial begin
      logic [143:0] d;
      int burst;
      int ang, elev;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed.push_back(make_item(0, 0, 0, 0, 0, 16'sd16384));
      directed.push_back(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'sd16384, 0, 0));
      directed.push_back(make_item(5, 6, 7, 0, 16'sd16384, 0));
      directed.push_back(make_item(5, 6, 7, 0, -16'sd16384, 0));
      directed.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
      directed.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   16'h8000, 16'h8000, 16'h8000));
      directed.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   16'h7FFF, 16'h7FFF, 16'h7FFF));
      directed.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   16'h8000, 16'h7FFF, 16'h7FFF));
      directed.push_back(make_item(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 16'h0001, 0, 0));
      directed.push_back(make_item(1, 1, 1, 0, 16'h7FFF, 16'hFFFF));
      directed.push_back(make_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                                   16'sd2000, 16'sd3000, 16'sd500));
      directed.push_back(make_item(0, 0, 0, 16'sd11585, 0, -16'sd11585));
      foreach (directed[i]) send(directed[i]);
      for (int n = 0; n < 320; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++, n++) begin
            for (int f = 0; f < 3; f++) begin
               case ($urandom_range(0, 3))
                  0: d[32*f +: 32] = $urandom;
                  1: d[32*f +: 32] = 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
                  default: d[32*f +: 32] = 32'($signed($urandom_range(0, 200000)) - 100000);
               endcase
            end
            ang = $urandom_range(0, 359);
            elev = $urandom_range(0, 178) - 89;
            case ($urandom_range(0, 9))
               0: d[143:96] = 48'({$urandom, $urandom});
               1: d[143:96] = {16'h0, 16'($urandom), 16'h0};
               default:
                  for (int f = 0; f < 3; f++) d[96 + 16*f +: 16] = unit_dir_part(f, ang, elev);
            endcase
            send(d);
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.rows_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
